/* rtl/pointer_button_tracker_top_macros.svh */
// Assertion macros shared by the pointer button tracker RTL.
// No dependencies; the files that check their own logic include it.
`ifndef POINTER_BUTTON_TRACKER_TOP_MACROS_SVH
`define POINTER_BUTTON_TRACKER_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled during reset
`define PBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled during reset
`define PBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define PBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/pbt_pkg.sv */
// Package of the pointer button tracker: payload structs, function and
// register codes, field widths. No dependencies.
`default_nettype none

package pbt_pkg;

    // Field widths
    localparam int POS_W   = 16;
    localparam int MOVE_W  = 12;
    localparam int CNT_W   = 16;
    localparam int MASK_W  = 8;
    localparam int FUNC_W  = 3;
    localparam int RAW_W   = 3;
    localparam int BIDX_W  = 3;
    localparam int CFG_IDX_W = 2;

    // Buttons that a report can actually press (left, right, middle)
    localparam int MAP_BUTTONS = 3;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_REPORT     = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET_POS    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ_DELTA = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_READ_COUNT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH      = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_X = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y = 2'd3;

    typedef struct packed {
        logic        [FUNC_W-1:0] func;
        logic        [RAW_W-1:0]  raw_buttons;
        logic signed [MOVE_W-1:0] move_dx;
        logic signed [MOVE_W-1:0] move_dy;
        logic signed [POS_W-1:0]  set_x;
        logic signed [POS_W-1:0]  set_y;
        logic        [BIDX_W-1:0] button_index;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic        [MASK_W-1:0] buttons_down;
        logic signed [POS_W-1:0]  delta_x;
        logic signed [POS_W-1:0]  delta_y;
        logic        [CNT_W-1:0]  down_count;
    } t_out_item;

    // Per-axis control decoded from the function code
    typedef struct packed {
        logic adv;
        logic report;
        logic set_pos;
        logic read_delta;
        logic flush;
    } t_axis_ctl;

endpackage

`default_nettype wire

/* rtl/pbt_axis.sv */
// One axis of the tracker: position register with limit clamp and a
// saturating motion accumulator. Depends on pbt_pkg.
`default_nettype none

module pbt_axis (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pbt_pkg::t_axis_ctl                i_ctl,
    input  logic signed [pbt_pkg::MOVE_W-1:0] i_move,
    input  logic signed [pbt_pkg::POS_W-1:0]  i_set,
    input  logic signed [pbt_pkg::POS_W-1:0]  i_lim_min,
    input  logic signed [pbt_pkg::POS_W-1:0]  i_lim_max,
    output logic signed [pbt_pkg::POS_W-1:0]  o_pos,
    output logic signed [pbt_pkg::POS_W-1:0]  o_delta
);
    import pbt_pkg::*;

    localparam int SUM_W = POS_W + 1;
    localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    logic signed [POS_W-1:0] r_pos, n_pos;
    logic signed [POS_W-1:0] r_acc, n_acc;
    logic signed [SUM_W-1:0] w_move;
    logic signed [SUM_W-1:0] w_pos_sum;
    logic signed [SUM_W-1:0] w_acc_sum;
    logic signed [SUM_W-1:0] w_target;
    logic signed [POS_W-1:0] w_clamped;
    logic signed [POS_W-1:0] w_acc_sat;

    // Sums, one bit wider than the state
    assign w_move    = SUM_W'(i_move);
    assign w_pos_sum = SUM_W'(r_pos) + w_move;
    assign w_acc_sum = SUM_W'(r_acc) + w_move;
    assign w_target  = i_ctl.report ? w_pos_sum : SUM_W'(i_set);

    // Clamp: maximum checked first, minimum only if max not exceeded
    always_comb begin
        if (w_target > SUM_W'(i_lim_max)) begin
            w_clamped = i_lim_max;
        end else if (w_target < SUM_W'(i_lim_min)) begin
            w_clamped = i_lim_min;
        end else begin
            w_clamped = w_target[POS_W-1:0];
        end
    end

    // Accumulator saturation: top two bits disagree on overflow
    always_comb begin
        if (w_acc_sum[SUM_W-1] != w_acc_sum[SUM_W-2]) begin
            w_acc_sat = w_acc_sum[SUM_W-1] ? POS_MIN : POS_MAX;
        end else begin
            w_acc_sat = w_acc_sum[POS_W-1:0];
        end
    end

    // Next state
    always_comb begin
        n_pos = r_pos;
        n_acc = r_acc;
        if (i_ctl.flush) begin
            n_pos = '0;
            n_acc = '0;
        end else if (i_ctl.report) begin
            n_pos = w_clamped;
            n_acc = w_acc_sat;
        end else if (i_ctl.set_pos) begin
            n_pos = w_clamped;
        end else if (i_ctl.read_delta) begin
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_acc <= '0;
        end else if (i_ctl.adv) begin
            r_pos <= n_pos;
            r_acc <= n_acc;
        end
    end

    assign o_pos   = n_pos;
    assign o_delta = i_ctl.read_delta ? r_acc : '0;

endmodule

`default_nettype wire

/* rtl/pointer_button_tracker_top.sv */
// Pointer button tracker top level: input and result registers, function
// decode, button counters, limit registers. Depends on pbt_pkg, pbt_axis.
//
// Usage:
//   Command items come in on the input channel (valid/ready). Each item
//   produces exactly one result item on the output channel (valid/ready).
//   A transfer on the input lands in the input register; once the result
//   register is free or being read, the step is computed and the result
//   lands in the result register, which drives o_out_valid.
//   Throughput is one item per cycle while the receiver takes results:
//   the state update is one short add-and-clamp between the two registers,
//   and the input register is refilled in the same cycle its item moves
//   to the result register. When the receiver stalls, the result register
//   holds; one more item waits in the input register, then o_in_ready drops.
//   The limit registers are written through i_cfg_we/i_cfg_index/i_cfg_data
//   with no wait; write them only while nothing is in flight.
//   Synchronous reset (i_rst_n low) clears position, accumulators, the
//   pressed mask, all press counters and the limits, and empties both
//   registers. There is no clearing pass.
`default_nettype none
`include "pointer_button_tracker_top_macros.svh"

module pointer_button_tracker_top #(
    parameter int NUM_BUTTONS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pbt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pbt_pkg::POS_W-1:0]        i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pbt_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pbt_pkg::t_out_item               o_out_data
);
    import pbt_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int SEL_W = IDX_W + BIDX_W;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic                    r_in_valid;
    t_in_item                r_in;
    logic                    r_out_valid;
    t_out_item               r_out, n_out;
    logic signed [POS_W-1:0] r_lim_min_x, r_lim_min_y, r_lim_max_x, r_lim_max_y;
    logic [MASK_W-1:0]       r_mask, n_mask;
    logic [CNT_W-1:0]        r_cnt [NUM_BUTTONS];
    logic [CNT_W-1:0]        n_cnt [NUM_BUTTONS];

    logic                    w_adv;
    t_axis_ctl               w_ctl;
    logic                    w_read_count;
    logic [MASK_W-1:0]       w_mapped;
    logic [MASK_W-1:0]       w_rise;
    logic [NUM_BUTTONS-1:0]  w_rise_b;
    logic [SEL_W-1:0]        w_sel_wide;
    logic [IDX_W-1:0]        w_sel;
    logic                    w_sel_ok;
    logic [CNT_W-1:0]        w_count;
    logic signed [POS_W-1:0] w_pos_x, w_pos_y, w_dlt_x, w_dlt_y;

    // Handshake: step runs when input register is full and result can move
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_min_x <= '0;
            r_lim_min_y <= '0;
            r_lim_max_x <= '0;
            r_lim_max_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MIN_X: r_lim_min_x <= i_cfg_data;
                CFG_MIN_Y: r_lim_min_y <= i_cfg_data;
                CFG_MAX_X: r_lim_max_x <= i_cfg_data;
                CFG_MAX_Y: r_lim_max_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Function decode; codes 5 to 7 change nothing
    always_comb begin
        w_ctl        = '0;
        w_ctl.adv    = w_adv;
        w_read_count = 1'b0;
        if (w_adv) begin
            unique case (r_in.func)
                FUNC_REPORT:     w_ctl.report     = 1'b1;
                FUNC_SET_POS:    w_ctl.set_pos    = 1'b1;
                FUNC_READ_DELTA: w_ctl.read_delta = 1'b1;
                FUNC_READ_COUNT: w_read_count     = 1'b1;
                FUNC_FLUSH:      w_ctl.flush      = 1'b1;
                default: ;
            endcase
        end
    end

    // Button remap: raw right -> 1, raw middle -> 2, raw left -> 0
    assign w_mapped = MASK_W'({r_in.raw_buttons[1], r_in.raw_buttons[0],
                               r_in.raw_buttons[2]});
    assign w_rise   = w_mapped & ~r_mask;
    assign w_rise_b = NUM_BUTTONS'(w_rise[MAP_BUTTONS-1:0]);

    // Selected counter for read-clear
    assign w_sel_wide = SEL_W'(r_in.button_index);
    assign w_sel_ok   = w_sel_wide < SEL_W'(NUM_BUTTONS);
    assign w_sel      = w_sel_wide[IDX_W-1:0];
    assign w_count    = (w_read_count && w_sel_ok) ? r_cnt[w_sel] : '0;

    // Pressed mask and press counters
    always_comb begin
        n_mask = r_mask;
        if (w_ctl.flush) begin
            n_mask = '0;
        end else if (w_ctl.report) begin
            n_mask = w_mapped;
        end
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            n_cnt[i] = r_cnt[i];
            if (w_ctl.flush) begin
                n_cnt[i] = '0;
            end else if (w_ctl.report && w_rise_b[i] && r_cnt[i] != CNT_MAX) begin
                n_cnt[i] = r_cnt[i] + 1'b1;
            end else if (w_read_count && w_sel_ok && w_sel == IDX_W'(i)) begin
                n_cnt[i] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_cnt[i] <= '0;
            end
        end else if (w_adv) begin
            r_mask <= n_mask;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    // Axes
    pbt_axis u_axis_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_move    (r_in.move_dx),
        .i_set     (r_in.set_x),
        .i_lim_min (r_lim_min_x),
        .i_lim_max (r_lim_max_x),
        .o_pos     (w_pos_x),
        .o_delta   (w_dlt_x)
    );

    pbt_axis u_axis_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_move    (r_in.move_dy),
        .i_set     (r_in.set_y),
        .i_lim_min (r_lim_min_y),
        .i_lim_max (r_lim_max_y),
        .o_pos     (w_pos_y),
        .o_delta   (w_dlt_y)
    );

    // Result register
    always_comb begin
        n_out.pos_x        = w_pos_x;
        n_out.pos_y        = w_pos_y;
        n_out.buttons_down = n_mask;
        n_out.delta_x      = w_dlt_x;
        n_out.delta_y      = w_dlt_y;
        n_out.down_count   = w_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Checks
    `PBT_ASSERT_NXT(a_step_fills_out, i_clk, i_rst_n, w_adv, r_out_valid, "step lost its result")
    `PBT_ASSERT_IMP(a_full_blocks_in, i_clk, i_rst_n, r_in_valid && r_out_valid && !i_out_ready, !o_in_ready, "input taken while both registers full")
    `PBT_ASSERT_NXT(a_flush_zero, i_clk, i_rst_n, w_ctl.flush, r_out.pos_x == 0 && r_out.pos_y == 0 && r_out.buttons_down == 0, "flush left state behind")
    `PBT_ASSERT_NXT(a_delta_only_read, i_clk, i_rst_n, w_adv && r_in.func != FUNC_READ_DELTA, r_out.delta_x == 0 && r_out.delta_y == 0, "delta shown outside read-delta")

endmodule

`default_nettype wire

/* dv/tb_pointer_button_tracker_top.sv */
// Testbench for pointer_button_tracker_top: directed rows, an accumulator
// saturation run, then random commands under changing limits.
// Depends on pbt_pkg and the RTL of the pointer button tracker.
`default_nettype none

module tb_pointer_button_tracker_top;
    import pbt_pkg::*;

    localparam int NUM_BTN        = 8;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RESULT_LATENCY = 2;
    localparam int SEG_ITEMS      = 90;
    localparam int SAT_REPORTS    = 20;
    localparam int POS_MAX        = 32767;
    localparam int POS_MIN        = -32768;
    localparam int MOVE_MAX       = 2047;
    localparam int MOVE_MIN       = -2048;
    localparam logic [CNT_W-1:0]  CNT_FULL = '1;
    // Function codes the block leaves unused
    localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

    // One row of the opening table: either a limit load or a command
    typedef struct {
        bit        is_lim;
        int        lo_x;
        int        lo_y;
        int        hi_x;
        int        hi_y;
        t_in_item  cmd;
        bit        typed;
        t_out_item want;
    } t_plan_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MIN_X;
    logic [POS_W-1:0]     i_cfg_data  = '0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_data;

    pointer_button_tracker_top #(
        .NUM_BUTTONS (NUM_BTN)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // Tracker state as the testbench sees it
    int               cur_x, cur_y, mot_x, mot_y;
    int               lim_lo_x, lim_lo_y, lim_hi_x, lim_hi_y;
    logic [MASK_W-1:0] held_mask = '0;
    logic [CNT_W-1:0] press_cnt [NUM_BTN];

    t_out_item pending_reports[$];
    t_plan_row opening_rows[$];
    int        mismatch_count, cycle_count, items_sent, results_seen;
    int        tx_idle_pct, rx_idle_pct, rx_hold_len, rx_hold_left;

    function automatic void clear_tracker();
        cur_x     = 0;
        cur_y     = 0;
        mot_x     = 0;
        mot_y     = 0;
        held_mask = '0;
        for (int b = 0; b < NUM_BTN; b++) press_cnt[b] = '0;
    endfunction

    function automatic int sat_acc(input int v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    // Max is tested first, so an inverted window pins a value above max to max, any other to min
    function automatic int clamp_to(input int v, input int lo, input int hi);
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    // Applies one command to the tracker state and returns its result
    function automatic t_out_item step_pointer(input t_in_item c);
        t_out_item        r;
        logic [2:0]       mapped;
        logic [2:0]       rise;
        int               dx, dy, sx, sy;
        r  = '0;
        dx = $signed(c.move_dx);
        dy = $signed(c.move_dy);
        sx = $signed(c.set_x);
        sy = $signed(c.set_y);
        case (c.func)
            FUNC_REPORT: begin
                // raw right -> 1, raw middle -> 2, raw left -> 0
                mapped = {c.raw_buttons[1], c.raw_buttons[0], c.raw_buttons[2]};
                rise   = mapped & ~held_mask[2:0];
                for (int b = 0; b < MAP_BUTTONS; b++) begin
                    if (rise[b] && press_cnt[b] != CNT_FULL) press_cnt[b] = press_cnt[b] + 1'b1;
                end
                held_mask = {{(MASK_W-3){1'b0}}, mapped};
                mot_x = sat_acc(mot_x + dx);
                mot_y = sat_acc(mot_y + dy);
                cur_x = clamp_to(cur_x + dx, lim_lo_x, lim_hi_x);
                cur_y = clamp_to(cur_y + dy, lim_lo_y, lim_hi_y);
            end
            FUNC_SET_POS: begin
                cur_x = clamp_to(sx, lim_lo_x, lim_hi_x);
                cur_y = clamp_to(sy, lim_lo_y, lim_hi_y);
            end
            FUNC_READ_DELTA: begin
                r.delta_x = mot_x[POS_W-1:0];
                r.delta_y = mot_y[POS_W-1:0];
                mot_x = 0;
                mot_y = 0;
            end
            FUNC_READ_COUNT: begin
                if (int'(c.button_index) < NUM_BTN) begin
                    r.down_count = press_cnt[c.button_index];
                    press_cnt[c.button_index] = '0;
                end
            end
            FUNC_FLUSH: clear_tracker();
            default: ;
        endcase
        r.pos_x        = cur_x[POS_W-1:0];
        r.pos_y        = cur_y[POS_W-1:0];
        r.buttons_down = held_mask;
        return r;
    endfunction

    function automatic t_plan_row cmd_row(input logic [FUNC_W-1:0] f, input logic [2:0] raw,
                                          input int dx, input int dy, input int sx,
                                          input int sy, input logic [2:0] bidx);
        t_plan_row r;
        r.is_lim           = 1'b0;
        r.lo_x             = 0;
        r.lo_y             = 0;
        r.hi_x             = 0;
        r.hi_y             = 0;
        r.typed            = 1'b0;
        r.want             = '0;
        r.cmd.func         = f;
        r.cmd.raw_buttons  = raw;
        r.cmd.move_dx      = dx[MOVE_W-1:0];
        r.cmd.move_dy      = dy[MOVE_W-1:0];
        r.cmd.set_x        = sx[POS_W-1:0];
        r.cmd.set_y        = sy[POS_W-1:0];
        r.cmd.button_index = bidx;
        return r;
    endfunction

    function automatic t_plan_row typed_as(input t_plan_row r, input int px, input int py,
                                           input logic [MASK_W-1:0] m, input int dlx,
                                           input int dly, input int cnt);
        r.typed              = 1'b1;
        r.want.pos_x         = px[POS_W-1:0];
        r.want.pos_y         = py[POS_W-1:0];
        r.want.buttons_down  = m;
        r.want.delta_x       = dlx[POS_W-1:0];
        r.want.delta_y       = dly[POS_W-1:0];
        r.want.down_count    = cnt[CNT_W-1:0];
        return r;
    endfunction

    function automatic t_plan_row lim_row(input int lx, input int ly, input int hx, input int hy);
        t_plan_row r;
        r        = cmd_row(FUNC_REPORT, 3'b000, 0, 0, 0, 0, 3'd0);
        r.is_lim = 1'b1;
        r.lo_x   = lx;
        r.lo_y   = ly;
        r.hi_x   = hx;
        r.hi_y   = hy;
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 40) $display("ERROR @%0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // Offer one command, wait for its transfer, then log its expected result
    task automatic send_cmd(input t_in_item c, input bit typed, input t_out_item want);
        t_out_item calc;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (!o_in_ready);
        calc = step_pointer(c);
        pending_reports.push_back(typed ? want : calc);
        items_sent++;
    endtask

    // Stop offering and wait until every result has come back
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    // Every command yields a result, so an empty queue means the block is idle
    task automatic load_limits(input int lx, input int ly, input int hx, input int hy);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_MIN_X;
        i_cfg_data  <= lx[POS_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_MIN_Y;
        i_cfg_data  <= ly[POS_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_X;
        i_cfg_data  <= hx[POS_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_MAX_Y;
        i_cfg_data  <= hy[POS_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lim_lo_x = lx;
        lim_lo_y = ly;
        lim_hi_x = hx;
        lim_hi_y = hy;
    endtask

    // Result side: random stalls, plus a long hold when one is requested
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_hold_len > 0) begin
            rx_hold_left = rx_hold_len - 1;
            rx_hold_len  = 0;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_reports.size() == 0) begin
                flag_mismatch("result with no command outstanding");
            end else begin
                want = pending_reports.pop_front();
                check_field("pos_x", o_out_data.pos_x, want.pos_x);
                check_field("pos_y", o_out_data.pos_y, want.pos_y);
                check_field("buttons_down", {8'h00, o_out_data.buttons_down},
                            {8'h00, want.buttons_down});
                check_field("delta_x", o_out_data.delta_x, want.delta_x);
                check_field("delta_y", o_out_data.delta_y, want.delta_y);
                check_field("down_count", o_out_data.down_count, want.down_count);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ERROR: run exceeded %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, pending_reports.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_in_item    c;
        t_plan_row   row;
        logic [31:0] rnd;
        int          pick, ax, ay, bx, by;
        clear_tracker();
        tx_idle_pct = 26;
        rx_idle_pct = 73;

        // Opening table: reset limits first, then wide, then an inverted window
        opening_rows.push_back(typed_as(cmd_row(FUNC_SPARE_5, 3'b000, 0, 0, 0, 0, 3'd0),
                                        0, 0, 8'h00, 0, 0, 0));
        opening_rows.push_back(typed_as(cmd_row(FUNC_SPARE_7, 3'b111, MOVE_MAX, MOVE_MIN,
                                                POS_MAX, POS_MIN, 3'd7),
                                        0, 0, 8'h00, 0, 0, 0));
        opening_rows.push_back(typed_as(cmd_row(FUNC_REPORT, 3'b111, MOVE_MAX, MOVE_MIN,
                                                0, 0, 3'd0),
                                        0, 0, 8'h07, 0, 0, 0));
        opening_rows.push_back(typed_as(cmd_row(FUNC_READ_DELTA, 3'b000, 0, 0, 0, 0, 3'd0),
                                        0, 0, 8'h07, MOVE_MAX, MOVE_MIN, 0));
        opening_rows.push_back(typed_as(cmd_row(FUNC_READ_COUNT, 3'b000, 0, 0, 0, 0, 3'd0),
                                        0, 0, 8'h07, 0, 0, 1));
        opening_rows.push_back(typed_as(cmd_row(FUNC_READ_COUNT, 3'b000, 0, 0, 0, 0, 3'd7),
                                        0, 0, 8'h07, 0, 0, 0));
        opening_rows.push_back(lim_row(POS_MIN, POS_MIN, POS_MAX, POS_MAX));
        opening_rows.push_back(cmd_row(FUNC_REPORT, 3'b001, MOVE_MIN, MOVE_MAX, 0, 0, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_REPORT, 3'b010, 1, -1, 0, 0, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_REPORT, 3'b100, -1, 1, 0, 0, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_REPORT, 3'b000, 0, 0, 0, 0, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_READ_COUNT, 3'b000, 0, 0, 0, 0, 3'd1));
        opening_rows.push_back(cmd_row(FUNC_READ_COUNT, 3'b000, 0, 0, 0, 0, 3'd2));
        opening_rows.push_back(typed_as(cmd_row(FUNC_SET_POS, 3'b000, 0, 0,
                                                POS_MAX, POS_MIN, 3'd0),
                                        POS_MAX, POS_MIN, 8'h00, 0, 0, 0));
        opening_rows.push_back(cmd_row(FUNC_REPORT, 3'b000, MOVE_MAX, MOVE_MIN, 0, 0, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_SET_POS, 3'b000, 0, 0, POS_MIN, POS_MAX, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_READ_DELTA, 3'b000, 0, 0, 0, 0, 3'd0));
        // Min above max on both axes
        opening_rows.push_back(lim_row(100, -10, 50, -20));
        opening_rows.push_back(cmd_row(FUNC_SET_POS, 3'b000, 0, 0, 75, -15, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_SET_POS, 3'b000, 0, 0, 0, -100, 3'd0));
        opening_rows.push_back(cmd_row(FUNC_REPORT, 3'b101, 3, 5, 0, 0, 3'd0));
        // Flush puts the position at zero even outside the window
        opening_rows.push_back(typed_as(cmd_row(FUNC_FLUSH, 3'b000, 0, 0, 0, 0, 3'd0),
                                        0, 0, 8'h00, 0, 0, 0));
        opening_rows.push_back(typed_as(cmd_row(FUNC_SPARE_6, 3'b110, 7, 9, 1, 2, 3'd3),
                                        0, 0, 8'h00, 0, 0, 0));
        opening_rows.push_back(cmd_row(FUNC_REPORT, 3'b101, 0, 0, 0, 0, 3'd0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[i]) begin
            if (opening_rows[i].is_lim) begin
                load_limits(opening_rows[i].lo_x, opening_rows[i].lo_y,
                            opening_rows[i].hi_x, opening_rows[i].hi_y);
            end else begin
                send_cmd(opening_rows[i].cmd, opening_rows[i].typed, opening_rows[i].want);
            end
        end

        // Saturation: accumulators and position driven into both rails
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_limits(POS_MIN, POS_MIN, POS_MAX, POS_MAX);
        for (int n = 0; n < SAT_REPORTS; n++) begin
            row = cmd_row(FUNC_REPORT, n[0] ? 3'b000 : 3'b111, MOVE_MAX, MOVE_MIN,
                          0, 0, 3'd0);
            send_cmd(row.cmd, 1'b0, '0);
        end
        row = cmd_row(FUNC_READ_DELTA, 3'b000, 0, 0, 0, 0, 3'd0);
        send_cmd(row.cmd, 1'b0, '0);
        for (int n = 0; n < SAT_REPORTS; n++) begin
            row = cmd_row(FUNC_REPORT, n[0] ? 3'b111 : 3'b000, MOVE_MIN, MOVE_MAX,
                          0, 0, 3'd0);
            send_cmd(row.cmd, 1'b0, '0);
        end
        row = cmd_row(FUNC_READ_DELTA, 3'b000, 0, 0, 0, 0, 3'd0);
        send_cmd(row.cmd, 1'b0, '0);
        for (int b = 0; b < 4; b++) begin
            row = cmd_row(FUNC_READ_COUNT, 3'b000, 0, 0, 0, 0, b[2:0]);
            send_cmd(row.cmd, 1'b0, '0);
        end

        // Random commands: three idle mixes, four limit windows each
        for (int mode = 0; mode < 3; mode++) begin
            tx_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 73 : 0;
            rx_idle_pct = (mode == 0) ? 73 : (mode == 1) ? 26 : 0;
            for (int seg = 0; seg < 4; seg++) begin
                rnd = $urandom;
                ax  = $signed(rnd[15:0]);
                bx  = $signed(rnd[31:16]);
                rnd = $urandom;
                ay  = $signed(rnd[15:0]);
                by  = $signed(rnd[31:16]);
                case (seg)
                    0: load_limits(POS_MIN, POS_MIN, POS_MAX, POS_MAX);
                    1: load_limits(ax < bx ? ax : bx, ay < by ? ay : by,
                                   ax < bx ? bx : ax, ay < by ? by : ay);
                    2: load_limits(ax, ay, bx, by);
                    default: begin
                        if (mode == 2) load_limits(POS_MAX, POS_MAX, POS_MIN, POS_MIN);
                        else load_limits(-$urandom_range(300), -$urandom_range(300),
                                         $urandom_range(300), $urandom_range(300));
                    end
                endcase
                // Long receiver hold while commands keep coming
                if ((mode == 0 && seg == 1) || (mode == 1 && seg == 2)) rx_hold_len = 120;
                for (int k = 0; k < SEG_ITEMS; k++) begin
                    pick = $urandom_range(99);
                    rnd  = $urandom;
                    if (pick < 50)      c.func = FUNC_REPORT;
                    else if (pick < 62) c.func = FUNC_SET_POS;
                    else if (pick < 74) c.func = FUNC_READ_DELTA;
                    else if (pick < 86) c.func = FUNC_READ_COUNT;
                    else if (pick < 90) c.func = FUNC_FLUSH;
                    else if (pick < 94) c.func = FUNC_SPARE_5;
                    else if (pick < 97) c.func = FUNC_SPARE_6;
                    else                c.func = FUNC_SPARE_7;
                    c.raw_buttons  = rnd[2:0];
                    c.button_index = rnd[5:3];
                    // Extreme moves now and then to reach the rails quickly
                    if (rnd[8:6] == 3'd0)      c.move_dx = rnd[9] ? 12'sh7FF : 12'sh800;
                    else                       c.move_dx = rnd[21:10];
                    rnd = $urandom;
                    if (rnd[2:0] == 3'd0)      c.move_dy = rnd[3] ? 12'sh7FF : 12'sh800;
                    else                       c.move_dy = rnd[15:4];
                    c.set_x = rnd[31:16];
                    rnd = $urandom;
                    c.set_y = rnd[15:0];
                    send_cmd(c, 1'b0, '0);
                end
            end
        end

        settle();
        repeat (RESULT_LATENCY + 6) @(posedge i_clk);
        $display("Ran %0d commands, %0d results checked, %0d mismatching fields",
                 items_sent, results_seen, mismatch_count);
        $display("Covered reset, wide, random and inverted limits, saturation and hold-offs");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
